// ===== src/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types and constants of the binary grid smoothing block.
// ----------------------------------------------------------------------------
package gcs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 7;
    localparam int PASS_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;
    localparam int LIVE_MIN   = 4;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_SMOOTH = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC,
        ST_P_START,
        ST_P_LOAD0,
        ST_P_RD,
        ST_P_CAP,
        ST_P_CALC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] above;
        logic [MAX_WIDTH-1:0] centre;
        logic [MAX_WIDTH-1:0] below;
        logic [MAX_WIDTH-1:0] col_mask;
    } row_win_t;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] new_row;
        logic                 changed;
    } row_res_t;

endpackage

// ===== src/binary_grid_cellular_smoothing_core.sv =====
// ----------------------------------------------------------------------------
// binary_grid_cellular_smoothing_core
// Cell grid with write, read, clear and 4-5 rule smoothing passes.
// Write and read go through ST_ACC_RD and ST_ACC to ST_OUT; clear goes straight
// to ST_OUT. Smoothing handles one row at a time; the row unit and the single
// RAM read port set this pace, and a pass that changes nothing ends the run.
// One item at a time; the next item is taken once the current one is done.
// Reset (async, rst_n low) empties the grid at once and sets the size to 64x64.
// ----------------------------------------------------------------------------
module binary_grid_cellular_smoothing_core
    import gcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // req_type[1:0], col[7:2], row[13:8], cell_in[14], pass_count[24:15]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cell_out[0], bad_coord[1]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]     width_reg, height_reg;
    logic [SIZE_W-1:0]     ncols, nrows;
    logic [1:0]            req_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic                  cell_reg;
    logic [PASS_W-1:0]     pass_reg;
    logic [ROW_W-1:0]      r_reg;
    logic                  changed_reg;
    logic                  cell_out_reg, bad_reg;
    logic                  m_valid_reg;
    logic                  m_cell_reg, m_bad_reg;
    logic [MAX_HEIGHT-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic [MAX_WIDTH-1:0]  above_reg, centre_reg, below_reg;
    logic [MAX_WIDTH-1:0]  col_mask;
    logic [MAX_WIDTH-1:0]  rd_data, rd_row, acc_row;
    logic [SIZE_W-1:0]     next_r;
    logic                  last_row, bad_now, out_free;

    logic                  wr_en;
    logic [ROW_W-1:0]      wr_addr, rd_addr;
    logic [MAX_WIDTH-1:0]  wr_data;

    row_win_t win;
    row_res_t res;

    assign ncols = (width_reg  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : width_reg;
    assign nrows = (height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_reg;

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            col_mask[c] = (SIZE_W'(c) < ncols);
        end
    end

    assign rd_row   = rd_valid_reg ? rd_data : '0;
    assign next_r   = SIZE_W'(r_reg) + SIZE_W'(1);
    assign last_row = (next_r >= nrows);
    assign bad_now  = (SIZE_W'(col_reg) >= ncols) || (SIZE_W'(row_reg) >= nrows);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        acc_row = rd_row;
        acc_row[col_reg] = cell_reg;
    end

    assign win.above    = above_reg;
    assign win.centre   = centre_reg;
    assign win.below    = below_reg;
    assign win.col_mask = col_mask;

    gcs_row_unit u_row (
        .win (win),
        .res (res)
    );

    gcs_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (req_t'(s_axis_tdata[1:0]))
                        REQ_WRITE, REQ_READ: state_next = ST_ACC_RD;
                        REQ_SMOOTH:          state_next = ST_P_START;
                        REQ_CLEAR:           state_next = ST_OUT;
                    endcase
                end
            end
            ST_ACC_RD:  state_next = ST_ACC;
            ST_ACC:     state_next = ST_OUT;
            ST_P_START:
            begin
                if (pass_reg == '0 || ncols == '0 || nrows == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_P_LOAD0;
                end
            end
            ST_P_LOAD0: state_next = ST_P_RD;
            ST_P_RD:    state_next = ST_P_CAP;
            ST_P_CAP:   state_next = ST_P_CALC;
            ST_P_CALC:
            begin
                if (!last_row)
                begin
                    state_next = ST_P_RD;
                end
                else if (!(changed_reg || res.changed) || pass_reg == PASS_W'(1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_P_START;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        wr_en   = 1'b0;
        wr_addr = r_reg;
        wr_data = res.new_row;
        rd_addr = r_reg;
        unique case (state_reg)
            ST_ACC_RD:  rd_addr = row_reg;
            ST_ACC:
            begin
                wr_addr = row_reg;
                wr_data = acc_row;
                wr_en   = (req_reg == REQ_WRITE) && !bad_now;
            end
            ST_P_START: rd_addr = '0;
            ST_P_RD:    rd_addr = next_r[ROW_W-1:0];
            ST_P_CALC:  wr_en = 1'b1;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            width_reg    <= SIZE_W'(MAX_WIDTH);
            height_reg   <= SIZE_W'(MAX_HEIGHT);
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_cell_reg   <= 1'b0;
            m_bad_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            changed_reg  <= 1'b0;
            cell_out_reg <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= valid_reg[rd_addr];
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_GRID_WIDTH:  width_reg  <= cfg_data;
                    CFG_GRID_HEIGHT: height_reg <= cfg_data;
                endcase
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            // load the output register, else drop the item once taken
            if (state_reg == ST_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
                m_cell_reg  <= cell_out_reg;
                m_bad_reg   <= bad_reg;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cell_out_reg <= 1'b0;
                    bad_reg      <= 1'b0;
                    changed_reg  <= 1'b0;
                    if (s_axis_tvalid && req_t'(s_axis_tdata[1:0]) == REQ_CLEAR)
                    begin
                        valid_reg <= '0;
                    end
                end
                ST_ACC:
                begin
                    bad_reg      <= bad_now;
                    cell_out_reg <= (req_reg == REQ_READ) && !bad_now && rd_row[col_reg];
                end
                ST_P_START: changed_reg <= 1'b0;
                ST_P_CALC:
                begin
                    if (res.changed)
                    begin
                        changed_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_reg  <= s_axis_tdata[1:0];
                    col_reg  <= s_axis_tdata[7:2];
                    row_reg  <= s_axis_tdata[13:8];
                    cell_reg <= s_axis_tdata[14];
                    pass_reg <= s_axis_tdata[24:15];
                end
            end
            ST_P_START:
            begin
                r_reg     <= '0;
                above_reg <= '0;
            end
            ST_P_LOAD0: centre_reg <= rd_row;
            ST_P_CAP:   below_reg  <= last_row ? '0 : rd_row;
            ST_P_CALC:
            begin
                above_reg  <= centre_reg;
                centre_reg <= below_reg;
                r_reg      <= next_r[ROW_W-1:0];
                if (last_row)
                begin
                    pass_reg <= pass_reg - PASS_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, m_bad_reg, m_cell_reg};

endmodule

// ===== src/gcs_ram.sv =====
// ----------------------------------------------------------------------------
// gcs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/gcs_row_unit.sv =====
// ----------------------------------------------------------------------------
// gcs_row_unit
// Applies the 4-5 rule to one grid row from a three-row window.
// ----------------------------------------------------------------------------
module gcs_row_unit
    import gcs_pkg::*;
(
    input  row_win_t win,
    output row_res_t res
);

    logic [MAX_WIDTH+1:0] a_ext, c_ext, b_ext;
    logic [MAX_WIDTH-1:0] rule_row;

    assign a_ext = {1'b0, win.above  & win.col_mask, 1'b0};
    assign c_ext = {1'b0, win.centre & win.col_mask, 1'b0};
    assign b_ext = {1'b0, win.below  & win.col_mask, 1'b0};

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            logic [3:0] n;
            n = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
              + 4'(c_ext[c]) + 4'(c_ext[c+2])
              + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
            if (win.centre[c])
            begin
                rule_row[c] = (n >= 4'(LIVE_MIN));
            end
            else
            begin
                rule_row[c] = (n > 4'(LIVE_MIN));
            end
        end
    end

    assign res.new_row = (rule_row & win.col_mask) | (win.centre & ~win.col_mask);
    assign res.changed = |((rule_row ^ win.centre) & win.col_mask);

endmodule
